// ===== rtl/core/acull_pkg.sv =====
package acull_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int FIELD_W     = 32;
    localparam int HALF_W      = 31;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_ROWS    = 3;
    localparam int NUM_PLANES  = 6;
    localparam int ROW_WORDS   = 4;

    // Shared multiplier operand widths and the limb size used to split wide values.
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int LIMB_W  = 32;

    localparam logic [1:0] CMD_ROW    = 2'd0;
    localparam logic [1:0] CMD_PLANE  = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ITEM_ROW,
        ITEM_PLANE,
        ITEM_TEST
    } item_kind_t;

    typedef struct packed {
        item_kind_t                         kind;
        logic [2:0]                         slot;
        logic [ROW_WORDS-1:0][FIELD_W-1:0]  word;
        logic [2:0][HALF_W-1:0]             half;
    } item_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_XFORM,
        ENG_XWAIT,
        ENG_PLANE,
        ENG_PWAIT,
        ENG_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        DST_CW,
        DST_HW,
        DST_ACC
    } dest_t;

endpackage

// ===== rtl/core/aabb_frustum_cull_core.sv =====
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | command, slot, word_a..d, center_x..z, half_x..z
// m_      | out       | m_valid / m_ready  | visible, plane_pass
//
// A load request is written to the stored matrix or planes as the engine takes it; a box test
// runs on the single shared multiplier: 18 products for the transform, 72 for the six plane sums.
// The front queue holds two requests, so requests are taken while a test is in progress.
// A finished result waits in the output register; only the next test's end waits on it.
// Reset is synchronous and active low and clears the stored matrix and planes to zero.
module aabb_frustum_cull_core
    import acull_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic [2:0]                s_slot,
    input  logic signed [FIELD_W-1:0] s_word_a,
    input  logic signed [FIELD_W-1:0] s_word_b,
    input  logic signed [FIELD_W-1:0] s_word_c,
    input  logic signed [FIELD_W-1:0] s_word_d,
    input  logic signed [FIELD_W-1:0] s_center_x,
    input  logic signed [FIELD_W-1:0] s_center_y,
    input  logic signed [FIELD_W-1:0] s_center_z,
    input  logic [HALF_W-1:0]         s_half_x,
    input  logic [HALF_W-1:0]         s_half_y,
    input  logic [HALF_W-1:0]         s_half_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_visible,
    output logic [5:0]                m_plane_pass
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    acull_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_slot     (s_slot),
        .s_word_a   (s_word_a),
        .s_word_b   (s_word_b),
        .s_word_c   (s_word_c),
        .s_word_d   (s_word_d),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_center_z (s_center_z),
        .s_half_x   (s_half_x),
        .s_half_y   (s_half_y),
        .s_half_z   (s_half_z),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    acull_engine #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_visible    (m_visible),
        .m_plane_pass (m_plane_pass)
    );

endmodule

// ===== rtl/core/acull_front.sv =====
module acull_front
    import acull_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic [2:0]                s_slot,
    input  logic signed [FIELD_W-1:0] s_word_a,
    input  logic signed [FIELD_W-1:0] s_word_b,
    input  logic signed [FIELD_W-1:0] s_word_c,
    input  logic signed [FIELD_W-1:0] s_word_d,
    input  logic signed [FIELD_W-1:0] s_center_x,
    input  logic signed [FIELD_W-1:0] s_center_y,
    input  logic signed [FIELD_W-1:0] s_center_z,
    input  logic [HALF_W-1:0]         s_half_x,
    input  logic [HALF_W-1:0]         s_half_y,
    input  logic [HALF_W-1:0]         s_half_z,
    output logic                      q_valid,
    input  logic                      q_ready,
    output item_t                     q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            fifo_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    item_t      in_item;
    item_kind_t kind;
    logic       cmd_ok;
    logic       push;
    logic       pop;

    // Requests with an unused command or an out-of-range slot are taken and dropped here.
    always_comb begin
        cmd_ok = 1'b0;
        kind   = ITEM_TEST;
        case (s_command)
            CMD_ROW: begin
                kind   = ITEM_ROW;
                cmd_ok = (s_slot < 3'(NUM_ROWS));
            end
            CMD_PLANE: begin
                kind   = ITEM_PLANE;
                cmd_ok = (s_slot < 3'(NUM_PLANES));
            end
            CMD_TEST: begin
                kind   = ITEM_TEST;
                cmd_ok = 1'b1;
            end
            default: begin
                kind   = ITEM_TEST;
                cmd_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        in_item.kind    = kind;
        in_item.slot    = s_slot;
        in_item.word[0] = (kind == ITEM_TEST) ? s_center_x : s_word_a;
        in_item.word[1] = (kind == ITEM_TEST) ? s_center_y : s_word_b;
        in_item.word[2] = (kind == ITEM_TEST) ? s_center_z : s_word_c;
        in_item.word[3] = s_word_d;
        in_item.half[0] = s_half_x;
        in_item.half[1] = s_half_y;
        in_item.half[2] = s_half_z;
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && cmd_ok;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/acull_engine.sv =====
module acull_engine
    import acull_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_visible,
    output logic [5:0] m_plane_pass
);

    localparam int WORD_W = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int CW_A   = 2 * WORD_W;
    localparam int CW_B   = WORD_W + FRAC_BITS;
    localparam int CW_W   = ((CW_A > CW_B) ? CW_A : CW_B) + 2;
    localparam int HW_W   = WORD_W + HALF_W + 1;
    localparam int ACC_A  = WORD_W + CW_W;
    localparam int ACC_B  = WORD_W + HW_W;
    localparam int ACC_C  = WORD_W + 2 * FRAC_BITS + 1;
    localparam int ACC_AB = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int ACC_W  = ((ACC_AB > ACC_C) ? ACC_AB : ACC_C) + 4;
    localparam int TERM_W = MUL_P_W + LIMB_W;

    localparam logic [1:0] XF_LAST_SUB = 2'd1;
    localparam logic [1:0] PL_LAST_SUB = 2'd3;
    localparam logic [1:0] LAST_IDX    = 2'(NUM_ROWS - 1);
    localparam logic [2:0] LAST_PLANE  = 3'(NUM_PLANES - 1);

    eng_state_t state_reg, state_next;

    logic signed [WORD_W-1:0] mat_reg   [NUM_ROWS][ROW_WORDS];
    logic signed [WORD_W-1:0] plane_reg [NUM_PLANES][ROW_WORDS];
    logic signed [WORD_W-1:0] cen_reg   [NUM_ROWS];
    logic [HALF_W-1:0]        half_reg  [NUM_ROWS];
    logic signed [CW_W-1:0]   cw_reg    [NUM_ROWS];
    logic [HW_W-1:0]          hw_reg    [NUM_ROWS];
    logic signed [ACC_W-1:0]  acc_reg;
    logic [5:0]               pass_reg;

    logic [1:0] sub_reg, sub_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] row_reg, row_next;
    logic [2:0] pidx_reg, pidx_next;

    // Product stage between the multiplier and the accumulators.
    logic                      pv_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic                      sh_reg;
    logic                      first_reg;
    logic                      last_reg;
    dest_t                     dst_reg;
    logic [1:0]                row_tag_reg;
    logic [2:0]                plane_tag_reg;
    logic signed [ACC_W-1:0]   base_reg;

    logic       m_valid_reg;
    logic       vis_reg;
    logic [5:0] pp_reg;

    logic issue;
    logic out_free;
    logic load_res;
    logic pop;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic                      is_sh;
    logic                      is_first;
    logic                      is_last;
    dest_t                     dst;
    logic signed [ACC_W-1:0]   base;
    logic [1:0]                row_tag;

    logic signed [WORD_W-1:0] m_ent;
    logic signed [WORD_W-1:0] t_ent;
    logic signed [WORD_W-1:0] n_ent;
    logic signed [WORD_W-1:0] d_ent;
    logic signed [WORD_W:0]   m_ext;
    logic signed [WORD_W:0]   n_ext;
    logic signed [WORD_W:0]   m_mag;
    logic signed [WORD_W:0]   n_mag;
    logic signed [CW_W-1:0]   cw_sel;
    logic [HW_W-1:0]          hw_sel;

    logic signed [TERM_W-1:0] term;
    logic signed [CW_W-1:0]   cw_sum;
    logic [HW_W-1:0]          hw_sum;
    logic signed [ACC_W-1:0]  acc_sum;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: begin
                if (q_valid && q_item.kind == ITEM_TEST) begin
                    state_next = ENG_XFORM;
                end
            end
            ENG_XFORM: begin
                if (row_reg == LAST_IDX && k_reg == LAST_IDX && sub_reg == XF_LAST_SUB) begin
                    state_next = ENG_XWAIT;
                end
            end
            ENG_XWAIT: state_next = ENG_PLANE;
            ENG_PLANE: begin
                if (pidx_reg == LAST_PLANE && k_reg == LAST_IDX && sub_reg == PL_LAST_SUB) begin
                    state_next = ENG_PWAIT;
                end
            end
            ENG_PWAIT: state_next = ENG_DONE;
            ENG_DONE: begin
                if (out_free) begin
                    state_next = ENG_IDLE;
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    always_comb begin
        q_ready  = (state_reg == ENG_IDLE);
        issue    = (state_reg == ENG_XFORM) || (state_reg == ENG_PLANE);
        load_res = (state_reg == ENG_DONE) && out_free;
    end

    assign pop = q_valid && q_ready;

    always_comb begin
        sub_next  = sub_reg;
        k_next    = k_reg;
        row_next  = row_reg;
        pidx_next = pidx_reg;
        case (state_reg)
            ENG_XFORM: begin
                if (sub_reg == XF_LAST_SUB) begin
                    sub_next = '0;
                    if (k_reg == LAST_IDX) begin
                        k_next   = '0;
                        row_next = row_reg + 1'b1;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    sub_next = sub_reg + 1'b1;
                end
            end
            ENG_PLANE: begin
                sub_next = sub_reg + 1'b1;
                if (sub_reg == PL_LAST_SUB) begin
                    if (k_reg == LAST_IDX) begin
                        k_next    = '0;
                        pidx_next = pidx_reg + 1'b1;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                sub_next  = '0;
                k_next    = '0;
                row_next  = '0;
                pidx_next = '0;
            end
        endcase
    end

    // Operand selection. In the plane phase the wide center and half-extent values
    // are split into an upper part and a lower 32-bit limb, one product each.
    always_comb begin
        m_ent  = mat_reg[row_reg][k_reg];
        t_ent  = mat_reg[row_reg][ROW_WORDS-1];
        n_ent  = plane_reg[pidx_reg][k_reg];
        d_ent  = plane_reg[pidx_reg][ROW_WORDS-1];
        m_ext  = (WORD_W+1)'(m_ent);
        n_ext  = (WORD_W+1)'(n_ent);
        m_mag  = m_ext[WORD_W] ? -m_ext : m_ext;
        n_mag  = n_ext[WORD_W] ? -n_ext : n_ext;
        cw_sel = cw_reg[k_reg];
        hw_sel = hw_reg[k_reg];

        op_a     = '0;
        op_b     = '0;
        is_sh    = 1'b0;
        is_first = 1'b0;
        is_last  = 1'b0;
        dst      = DST_CW;
        base     = '0;
        row_tag  = row_reg;

        if (state_reg == ENG_XFORM) begin
            is_first = (k_reg == '0);
            if (sub_reg == '0) begin
                op_a = MUL_A_W'(m_ent);
                op_b = MUL_B_W'(cen_reg[k_reg]);
                dst  = DST_CW;
                base = ACC_W'(t_ent) <<< FRAC_BITS;
            end else begin
                op_a = MUL_A_W'(m_mag);
                op_b = MUL_B_W'($signed({1'b0, half_reg[k_reg]}));
                dst  = DST_HW;
            end
        end else begin
            dst      = DST_ACC;
            is_first = (k_reg == '0) && (sub_reg == '0);
            is_last  = (k_reg == LAST_IDX) && (sub_reg == PL_LAST_SUB);
            base     = -(ACC_W'(d_ent) <<< (2 * FRAC_BITS));
            case (sub_reg)
                2'd0: begin
                    op_a  = MUL_A_W'(cw_sel >>> LIMB_W);
                    op_b  = MUL_B_W'(n_ent);
                    is_sh = 1'b1;
                end
                2'd1: begin
                    op_a = MUL_A_W'($signed({1'b0, cw_sel[LIMB_W-1:0]}));
                    op_b = MUL_B_W'(n_ent);
                end
                2'd2: begin
                    op_a  = MUL_A_W'($signed({1'b0, hw_sel[HW_W-1:LIMB_W]}));
                    op_b  = MUL_B_W'(n_mag);
                    is_sh = 1'b1;
                end
                default: begin
                    op_a = MUL_A_W'($signed({1'b0, hw_sel[LIMB_W-1:0]}));
                    op_b = MUL_B_W'(n_mag);
                end
            endcase
        end
    end

    always_comb begin
        term = TERM_W'(prod_reg);
        if (sh_reg) begin
            term = term <<< LIMB_W;
        end
        cw_sum  = (first_reg ? CW_W'(base_reg) : cw_reg[row_tag_reg]) + CW_W'(term);
        hw_sum  = (first_reg ? '0 : hw_reg[row_tag_reg]) + HW_W'(term);
        acc_sum = (first_reg ? base_reg : acc_reg) + ACC_W'(term);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ENG_IDLE;
            sub_reg     <= '0;
            k_reg       <= '0;
            row_reg     <= '0;
            pidx_reg    <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ROWS; i++) begin
                for (int j = 0; j < ROW_WORDS; j++) begin
                    mat_reg[i][j] <= '0;
                end
            end
            for (int i = 0; i < NUM_PLANES; i++) begin
                for (int j = 0; j < ROW_WORDS; j++) begin
                    plane_reg[i][j] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            k_reg     <= k_next;
            row_reg   <= row_next;
            pidx_reg  <= pidx_next;
            pv_reg    <= issue;
            if (load_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop && q_item.kind == ITEM_ROW) begin
                for (int j = 0; j < ROW_WORDS; j++) begin
                    mat_reg[q_item.slot[1:0]][j] <= q_item.word[j][WORD_W-1:0];
                end
            end
            if (pop && q_item.kind == ITEM_PLANE) begin
                for (int j = 0; j < ROW_WORDS; j++) begin
                    plane_reg[q_item.slot][j] <= q_item.word[j][WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_item.kind == ITEM_TEST) begin
            for (int j = 0; j < NUM_ROWS; j++) begin
                cen_reg[j]  <= q_item.word[j][WORD_W-1:0];
                half_reg[j] <= q_item.half[j];
            end
        end
        prod_reg      <= op_a * op_b;
        sh_reg        <= is_sh;
        first_reg     <= is_first;
        last_reg      <= is_last;
        dst_reg       <= dst;
        row_tag_reg   <= row_tag;
        plane_tag_reg <= pidx_reg;
        base_reg      <= base;
        if (pv_reg) begin
            case (dst_reg)
                DST_CW: cw_reg[row_tag_reg] <= cw_sum;
                DST_HW: hw_reg[row_tag_reg] <= hw_sum;
                DST_ACC: begin
                    acc_reg <= acc_sum;
                    if (last_reg) begin
                        pass_reg[plane_tag_reg] <= ~acc_sum[ACC_W-1];
                    end
                end
                default: begin
                end
            endcase
        end
        if (load_res) begin
            vis_reg <= &pass_reg;
            pp_reg  <= pass_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_visible    = vis_reg;
    assign m_plane_pass = pp_reg;

endmodule

// ===== bench/tb_aabb_frustum_cull_core.sv =====
`timescale 1ns / 1ps

module tb_aabb_frustum_cull_core;
    import acull_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LIMIT_CYCLES = 1000000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_command;
    logic [2:0]                s_slot;
    logic signed [FIELD_W-1:0] s_word_a, s_word_b, s_word_c, s_word_d;
    logic signed [FIELD_W-1:0] s_center_x, s_center_y, s_center_z;
    logic [HALF_W-1:0]         s_half_x, s_half_y, s_half_z;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_visible;
    logic [5:0]                m_plane_pass;

    aabb_frustum_cull_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_slot(s_slot),
        .s_word_a(s_word_a), .s_word_b(s_word_b), .s_word_c(s_word_c), .s_word_d(s_word_d),
        .s_center_x(s_center_x), .s_center_y(s_center_y), .s_center_z(s_center_z),
        .s_half_x(s_half_x), .s_half_y(s_half_y), .s_half_z(s_half_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_visible(m_visible), .m_plane_pass(m_plane_pass)
    );

    typedef struct {
        logic [1:0]         cmd;
        logic [2:0]         slot;
        logic signed [31:0] w[4];
        logic signed [31:0] c[3];
        logic [30:0]        h[3];
        bit                 known;
        logic [5:0]         pass;
    } request_t;

    typedef struct {
        logic       visible;
        logic [5:0] pass;
    } verdict_t;

    logic signed [31:0] model_m[12];
    logic signed [31:0] planes_m[24];
    verdict_t verdict_q[$];
    int errors;
    int cycles;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Exact arithmetic: 200 bits covers Q48 products of three-term sums.
    function automatic verdict_t cull_box(request_t r);
        logic signed [199:0] cw[3], hw[3], acc;
        logic signed [199:0] mabs, nabs;
        verdict_t v;
        v.pass = '0;
        for (int i = 0; i < 3; i++) begin
            cw[i] = 200'(model_m[i*4+3]) <<< FB;
            hw[i] = '0;
            for (int k = 0; k < 3; k++) begin
                mabs = model_m[i*4+k] < 0 ? -200'(model_m[i*4+k]) : 200'(model_m[i*4+k]);
                cw[i] += 200'(model_m[i*4+k]) * 200'(r.c[k]);
                hw[i] += mabs * $signed({169'b0, r.h[k]});
            end
        end
        for (int p = 0; p < 6; p++) begin
            acc = -(200'(planes_m[p*4+3]) <<< (2*FB));
            for (int i = 0; i < 3; i++) begin
                nabs = planes_m[p*4+i] < 0 ? -200'(planes_m[p*4+i]) : 200'(planes_m[p*4+i]);
                acc += cw[i] * 200'(planes_m[p*4+i]) + hw[i] * nabs;
            end
            v.pass[p] = (acc >= 0);
        end
        v.visible = (v.pass == 6'h3f);
        return v;
    endfunction

    task automatic apply_request(request_t r);
        verdict_t v;
        if (r.cmd == CMD_ROW && r.slot < NUM_ROWS)
            for (int k = 0; k < 4; k++) model_m[r.slot*4+k] = r.w[k];
        else if (r.cmd == CMD_PLANE && r.slot < NUM_PLANES)
            for (int k = 0; k < 4; k++) planes_m[r.slot*4+k] = r.w[k];
        else if (r.cmd == CMD_TEST) begin
            v = cull_box(r);
            if (r.known && v.pass != r.pass)
                report_mismatch("table row", v.pass, r.pass);
            verdict_q.push_back(v);
        end
    endtask

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result check and receiver stall pattern.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result", m_plane_pass, 0);
            end else begin
                if (m_visible !== verdict_q[0].visible)
                    report_mismatch("visible", m_visible, verdict_q[0].visible);
                if (m_plane_pass !== verdict_q[0].pass)
                    report_mismatch("plane_pass", m_plane_pass, verdict_q[0].pass);
                void'(verdict_q.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else if ((cycles / 400) % 3 == 0) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    function automatic request_t make_req(logic [1:0] cmd, logic [2:0] slot);
        request_t r;
        r.cmd = cmd;
        r.slot = slot;
        r.known = 0;
        r.pass = '0;
        for (int k = 0; k < 4; k++) r.w[k] = $urandom;
        for (int k = 0; k < 3; k++) begin
            r.c[k] = $urandom;
            r.h[k] = 31'($urandom);
        end
        return r;
    endfunction

    // Small Q16.16 magnitudes give boxes that straddle planes both ways.
    function automatic logic signed [31:0] modest();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    task automatic send(request_t r);
        s_valid    <= 1;
        s_command  <= r.cmd;
        s_slot     <= r.slot;
        s_word_a   <= r.w[0];
        s_word_b   <= r.w[1];
        s_word_c   <= r.w[2];
        s_word_d   <= r.w[3];
        s_center_x <= r.c[0];
        s_center_y <= r.c[1];
        s_center_z <= r.c[2];
        s_half_x   <= r.h[0];
        s_half_y   <= r.h[1];
        s_half_z   <= r.h[2];
        do @(posedge aclk); while (!s_ready);
        apply_request(r);
        @(negedge aclk);
    endtask

    task automatic pause();
        s_valid <= 0;
        repeat ($urandom_range(1, 12)) @(negedge aclk);
    endtask

    request_t stim_table[$];

    initial begin
        request_t r;
        int burst;
        errors = 0;
        cycles = 0;
        aresetn = 0;
        s_valid = 0;
        s_command = CMD_ROW; s_slot = 0;
        s_word_a = 0; s_word_b = 0; s_word_c = 0; s_word_d = 0;
        s_center_x = 0; s_center_y = 0; s_center_z = 0;
        s_half_x = 0; s_half_y = 0; s_half_z = 0;
        foreach (model_m[i]) model_m[i] = 0;
        foreach (planes_m[i]) planes_m[i] = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Zero state after reset: every plane passes.
        r = make_req(CMD_TEST, 3'd0); r.known = 1; r.pass = 6'h3f;
        stim_table.push_back(r);
        // Out-of-range slots and the unused command are dropped, so state stays zero.
        r = make_req(CMD_ROW, 3'd7); stim_table.push_back(r);
        r = make_req(CMD_PLANE, 3'd6); stim_table.push_back(r);
        r = make_req(CMD_UNUSED, 3'd0); stim_table.push_back(r);
        r = make_req(CMD_TEST, 3'd0);
        r.c = '{32'sh7fffffff, 32'sh80000000, 32'shffffffff};
        r.h = '{31'h7fffffff, 31'h0, 31'h7fffffff};
        r.known = 1; r.pass = 6'h3f;
        stim_table.push_back(r);
        // Extreme matrix and planes.
        for (int i = 0; i < 3; i++) begin
            r = make_req(CMD_ROW, 3'(i));
            r.w = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
            stim_table.push_back(r);
        end
        for (int p = 0; p < 6; p++) begin
            r = make_req(CMD_PLANE, 3'(p));
            r.w = p[0] ? '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000}
                       : '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
            stim_table.push_back(r);
        end
        r = make_req(CMD_TEST, 3'd0);
        r.c = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        r.h = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
        stim_table.push_back(r);
        r = make_req(CMD_TEST, 3'd0);
        r.c = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        r.h = '{31'h0, 31'h0, 31'h0};
        stim_table.push_back(r);
        for (int k = 0; k < 4; k++) stim_table.push_back(make_req(CMD_TEST, 3'd0));

        foreach (stim_table[i]) send(stim_table[i]);
        pause();

        for (int n = 0; n < 1900; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++, n++) begin
                case ($urandom_range(0, 9))
                    0: r = make_req(CMD_ROW, 3'($urandom_range(0, 7)));
                    1: r = make_req(CMD_PLANE, 3'($urandom_range(0, 7)));
                    2: r = make_req(CMD_UNUSED, 3'($urandom));
                    3: begin
                        r = make_req(($urandom_range(0, 1) != 0) ? CMD_PLANE : CMD_ROW,
                                     3'($urandom_range(0, 2)));
                        for (int k = 0; k < 4; k++) r.w[k] = modest();
                    end
                    4, 5: r = make_req(CMD_TEST, 3'($urandom));
                    default: begin
                        r = make_req(CMD_TEST, 3'($urandom));
                        for (int k = 0; k < 3; k++) begin
                            r.c[k] = modest();
                            r.h[k] = 31'($urandom_range(0, 32'h0002_0000));
                        end
                    end
                endcase
                send(r);
            end
            if ($urandom_range(0, 3) != 0) pause();
        end
        s_valid <= 0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
